@@ hdl/sha_pkg.sv @@
// Package: SHA-256 constants, types and round functions shared by the hasher.
`timescale 1ns / 1ps
package sha_pkg;

   localparam int BlockBytes = 64;
   localparam int LenBits    = 61;

   typedef logic [31:0] word_type;
   typedef word_type    state_type [8];

   // Register indexes on the configuration port.
   localparam logic [0:0] REG_DIFFICULTY = 1'b0;
   localparam logic [8:0] DifficultyReset = 9'd16;

   // Queue entry between the byte front end and the compression engine.
   typedef struct packed {
      logic [511:0] block;
      logic         final_blk;
   } job_type;

   // Result of one message.
   typedef struct packed {
      logic [255:0] digest;
      logic [8:0]   lzc;
      logic         pass;
   } result_type;

   function automatic word_type init_hash(input logic [2:0] i);
      word_type r;
      case (i)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   function automatic word_type round_k(input logic [5:0] i);
      word_type r;
      case (i)
         6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
         6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
         6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
         6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
         6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
         6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
         6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
         6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
         6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
         6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
         6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
         6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
         6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
         6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
         6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
         6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
         6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
         6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
         6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
         6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
         6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
         6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
         6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
      endcase
      return r;
   endfunction

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

@@ hdl/sha_if.sv @@
// Valid/ready channel interfaces for the request and response streams.
`timescale 1ns / 1ps
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_present;
   logic       last_byte;
   modport source (output valid, data_byte, byte_present, last_byte, input ready);
   modport sink (input valid, data_byte, byte_present, last_byte, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_part_0;
   logic [63:0] digest_part_1;
   logic [63:0] digest_part_2;
   logic [63:0] digest_part_3;
   logic [8:0]  leading_zero_bits;
   logic        meets_difficulty;
   modport source (output valid, digest_part_0, digest_part_1, digest_part_2,
                   digest_part_3, leading_zero_bits, meets_difficulty, input ready);
   modport sink (input valid, digest_part_0, digest_part_1, digest_part_2,
                 digest_part_3, leading_zero_bits, meets_difficulty, output ready);
endinterface

@@ hdl/sha_front.sv @@
// Front end: gathers bytes into 512-bit blocks and builds the padding blocks.
`timescale 1ns / 1ps
module sha_front
   import sha_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   sha_req_if.sink req,
   output job_type job,
   output logic    job_valid,
   input  logic    job_ready
);

   typedef enum logic [2:0] {
      ST_FILL = 3'b001,
      ST_PAD1 = 3'b010,
      ST_PAD2 = 3'b100
   } st_type;

   st_type             state_ff, state_in;
   logic [511:0]       buf_ff, buf_in;
   logic [LenBits-1:0] len_ff, len_in;
   logic               ovf_ff, ovf_in;     // second block of padding is needed
   logic               jv_ff, jv_in;
   job_type            job_ff, job_in;
   logic [5:0]         pos;
   logic [63:0]        bitlen;
   logic               acc, slot_free;

   assign slot_free = !jv_ff || job_ready;
   assign req.ready = (state_ff == ST_FILL) && slot_free;
   assign acc       = req.valid && req.ready;
   assign job       = job_ff;
   assign job_valid = jv_ff;

   // Byte slot of the next message byte; bit count of the message.
   assign pos    = len_ff[5:0];
   assign bitlen = {len_ff, 3'b000};

   always_comb begin
      logic [511:0] b;
      logic [LenBits-1:0] l;
      logic [5:0] p;
      b        = buf_ff;
      l        = len_ff;
      p        = pos;
      state_in = state_ff;
      buf_in   = buf_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      jv_in    = jv_ff && !job_ready;
      job_in   = job_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (acc) begin
               if (req.byte_present) begin
                  b[511 - 8*p -: 8] = req.data_byte;
                  l = len_ff + 1'b1;
               end
               len_in = l;
               buf_in = b;
               if (req.byte_present && (l[5:0] == 6'd0)) begin
                  // Full block: hand over.
                  job_in = '{block: b, final_blk: 1'b0};
                  jv_in  = 1'b1;
               end
               if (req.last_byte) begin
                  state_in = ST_PAD1;
               end
            end
         end
         ST_PAD1: begin
            if (slot_free) begin
               // Append 0x80 and clear the rest of the block.
               for (int i = 0; i < BlockBytes; i++) begin
                  if (i[5:0] == pos) begin
                     b[511 - 8*i -: 8] = 8'h80;
                  end else if (i[5:0] > pos) begin
                     b[511 - 8*i -: 8] = 8'h00;
                  end
               end
               if (pos >= 6'd56) begin
                  job_in   = '{block: b, final_blk: 1'b0};
                  jv_in    = 1'b1;
                  state_in = ST_PAD2;
                  buf_in   = '0;
                  ovf_in   = 1'b1;
               end else begin
                  b[63:0]  = bitlen;
                  job_in   = '{block: b, final_blk: 1'b1};
                  jv_in    = 1'b1;
                  state_in = ST_FILL;
                  len_in   = '0;
               end
            end
         end
         ST_PAD2: begin
            if (slot_free) begin
               job_in   = '{block: {448'd0, bitlen}, final_blk: 1'b1};
               jv_in    = 1'b1;
               state_in = ST_FILL;
               len_in   = '0;
               ovf_in   = 1'b0;
            end
         end
         default: state_in = ST_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         len_ff   <= '0;
         jv_ff    <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         jv_ff    <= jv_in;
         ovf_ff   <= ovf_in;
      end
      buf_ff <= buf_in;
      job_ff <= job_in;
   end

   // Padding states never accept a beat.
   a_pad_stall: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_FILL) |-> !req.ready) else $error("beat taken while padding");
   a_pad2_flag: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (state_ff == ST_PAD2)) else $error("pad flag out of step");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (jv_ff && !job_ready) |=> (jv_ff && $stable(job_ff))) else $error("job dropped");

endmodule

@@ hdl/sha_engine.sv @@
// Compression engine: one SHA-256 round per cycle, digest finish and result register.
`timescale 1ns / 1ps
module sha_engine
   import sha_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  job_type    job,
   input  logic       job_valid,
   output logic       job_ready,
   input  logic [8:0] difficulty,
   sha_rsp_if.source  rsp
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ROUND = 4'b0010,
      ST_ADD   = 4'b0100,
      ST_LZC   = 4'b1000
   } st_type;

   st_type       state_ff, state_in;
   word_type     h_ff [8];
   word_type     v_ff [8];
   word_type     w_ff [16];            // message schedule window
   logic [5:0]   rnd_ff;
   logic         fin_ff;
   logic [2:0]   lz_idx_ff;            // word scan for the leading-zero count
   logic [8:0]   lz_ff;
   logic         rv_ff;
   result_type   res_ff;
   word_type     t1, t2, s0, s1, wnew, e, a, ch, mj, wcur, x;
   logic [5:0]   clz;

   assign job_ready = (state_ff == ST_IDLE) && !(rv_ff && !rsp.ready);

   // Round datapath.
   assign e    = v_ff[4];
   assign a    = v_ff[0];
   assign wcur = w_ff[0];
   assign ch   = (e & v_ff[5]) ^ (~e & v_ff[6]);
   assign mj   = (a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t1   = v_ff[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ch
                 + round_k(rnd_ff) + wcur;
   assign t2   = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + mj;
   assign s0   = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
   assign s1   = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
   assign wnew = s1 + w_ff[9] + s0 + w_ff[0];

   // Leading zeros of the current word.
   assign x = h_ff[lz_idx_ff];
   always_comb begin
      clz = 6'd32;
      for (int i = 0; i < 32; i++) begin
         if (x[i]) begin
            clz = 6'(31 - i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (job_valid && job_ready) state_in = ST_ROUND;
         ST_ROUND: if (rnd_ff == 6'd63) state_in = ST_ADD;
         ST_ADD:   state_in = fin_ff ? ST_LZC : ST_IDLE;
         ST_LZC:   if (clz != 6'd32 || lz_idx_ff == 3'd7) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
      end else begin
         state_ff <= state_in;
         // Raise the result beat at scan end; drop it once taken.
         if (state_ff == ST_LZC && state_in == ST_IDLE) begin
            rv_ff <= 1'b1;
         end else if (rsp.ready) begin
            rv_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
            end
            ST_LZC: begin
               if (state_in == ST_IDLE) begin
                  // Emit result and restart the chain.
                  res_ff.lzc <= lz_ff + 9'(clz);
                  res_ff.pass <= (lz_ff + 9'(clz)) >= difficulty;
                  for (int i = 0; i < 8; i++) begin
                     res_ff.digest[255 - 32*i -: 32] <= h_ff[i];
                     h_ff[i] <= init_hash(3'(i));
                  end
               end
            end
            default: ;
         endcase
      end
      unique case (state_ff)
         ST_IDLE: begin
            rnd_ff    <= '0;
            lz_idx_ff <= '0;
            lz_ff     <= '0;
            fin_ff    <= job.final_blk;
            for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
            for (int i = 0; i < 16; i++) w_ff[i] <= job.block[511 - 32*i -: 32];
         end
         ST_ROUND: begin
            rnd_ff <= rnd_ff + 1'b1;
            v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
            v_ff[4] <= v_ff[3] + t1;
            v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
            v_ff[0] <= t1 + t2;
            for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
            w_ff[15] <= wnew;
         end
         ST_LZC: begin
            lz_ff     <= lz_ff + 9'(clz);
            lz_idx_ff <= lz_idx_ff + 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp.valid             = rv_ff;
   assign rsp.digest_part_0     = res_ff.digest[255:192];
   assign rsp.digest_part_1     = res_ff.digest[191:128];
   assign rsp.digest_part_2     = res_ff.digest[127:64];
   assign rsp.digest_part_3     = res_ff.digest[63:0];
   assign rsp.leading_zero_bits = res_ff.lzc;
   assign rsp.meets_difficulty  = res_ff.pass;

   a_round_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff == 6'd63) |=> (state_ff == ST_ADD))
      else $error("round count off");
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !job_ready) else $error("job taken while busy");
   a_lz_range: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> (res_ff.lzc <= 9'd256)) else $error("zero count out of range");

endmodule

@@ hdl/sha256_pow_hasher.sv @@
// Top level: streaming SHA-256 hasher with leading-zero difficulty check.
//
// Request channel (req_): one beat per message byte; byte_present marks a real
// byte, last_byte closes the message. Response channel (rsp_): one beat per
// message with the 256-bit digest in four 64-bit parts, its count of leading
// zero bits and the pass flag against difficulty_bits.
// A front end packs bytes into 512-bit blocks and builds padding; a one-entry
// job register hands blocks to the compression engine, which runs one round
// per cycle: a load, the rounds and an add for each block.
// Bytes are taken one per cycle while the job register is free or being emptied;
// a block waits in the job register when the engine is busy, holding req_ready
// low until the engine takes it. At message end padding builds one or two blocks
// (two when fewer than 9 bytes remain in the last block). The leading-zero scan
// reads the digest a word at a time and stops at the first nonzero word; the
// digest appears after the add of the final block and that scan.
// A stalled response holds the engine before its next block.
// Reset restores the initial hash values, clears the length and sets
// difficulty_bits to 16. The CSR port holds difficulty_bits at address 0.
`timescale 1ns / 1ps
module sha256_pow_hasher
   import sha_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   sha_req_if.sink     req,
   sha_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   job_type    job;
   logic       job_valid, job_ready;
   logic [8:0] diff_ff;

   // Configuration register.
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1] == 1'b0 && csr_paddr[0] == REG_DIFFICULTY) ?
                       {23'd0, diff_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_ff <= DifficultyReset;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr == {1'b0, REG_DIFFICULTY}) begin
         diff_ff <= csr_pwdata[8:0];
      end
   end

   sha_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .job       (job),
      .job_valid (job_valid),
      .job_ready (job_ready)
   );

   sha_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .job        (job),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .difficulty (diff_ff),
      .rsp        (rsp)
   );

endmodule
